>>> design/stg_pkg.sv
`timescale 1ns / 1ps

package stg_pkg;

   // Request kinds
   localparam logic [1:0] KIND_NOTE   = 2'd0;
   localparam logic [1:0] KIND_PWM    = 2'd1;
   localparam logic [1:0] KIND_CSTICK = 2'd2;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int FREQ_W   = 15;
   localparam int DUR_W    = 8;
   localparam int VAL_W    = 16;
   localparam int ELAPSE_W = 9;
   localparam int ROM_W    = 10;
   localparam int ROM_AW   = 5;
   localparam int ROM_SIZE = 32;
   localparam int HZ_W     = 12;
   localparam int DEN_W    = 16;

   localparam logic [ELAPSE_W-1:0] MAX_ELAPSED = 9'd511;
   localparam logic [VAL_W-1:0]    MAX16       = 16'hFFFF;

   // freq / 10 as multiply by reciprocal, exact for all 15-bit inputs
   localparam int DIV10_MUL_W = 16;
   localparam int DIV10_PROD_W = FREQ_W + DIV10_MUL_W;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
   localparam int DIV10_SHIFT = 19;

   // Defaults for the top-level parameters
   localparam int DEF_TABLE_POINTS    = 32;
   localparam int DEF_AMPLITUDE_RANGE = 1000;
   localparam int DEF_CLOCK_HZ        = 16000000;

   function automatic logic [ROM_W-1:0] sine_value(input logic [ROM_AW-1:0] addr);
      logic [ROM_W-1:0] val;
      case (addr)
         5'd0:  val = 10'd500;
         5'd1:  val = 10'd598;
         5'd2:  val = 10'd691;
         5'd3:  val = 10'd778;
         5'd4:  val = 10'd854;
         5'd5:  val = 10'd916;
         5'd6:  val = 10'd962;
         5'd7:  val = 10'd990;
         5'd8:  val = 10'd999;
         5'd9:  val = 10'd990;
         5'd10: val = 10'd962;
         5'd11: val = 10'd916;
         5'd12: val = 10'd854;
         5'd13: val = 10'd778;
         5'd14: val = 10'd691;
         5'd15: val = 10'd598;
         5'd16: val = 10'd500;
         5'd17: val = 10'd402;
         5'd18: val = 10'd309;
         5'd19: val = 10'd222;
         5'd20: val = 10'd146;
         5'd21: val = 10'd84;
         5'd22: val = 10'd38;
         5'd23: val = 10'd10;
         5'd24: val = 10'd1;
         5'd25: val = 10'd10;
         5'd26: val = 10'd38;
         5'd27: val = 10'd84;
         5'd28: val = 10'd146;
         5'd29: val = 10'd222;
         5'd30: val = 10'd309;
         default: val = 10'd402;
      endcase
      return val;
   endfunction

endpackage

>>> design/sine_pwm_tone_generator.sv
`timescale 1ns / 1ps

// Sine-table PWM tone generator.
// Request channel (req_): one request per accepted beat. req_tuser carries the
// kind: note command, PWM period tick or centisecond tick. A note carries the
// frequency in decihertz and the length in centiseconds in req_tdata.
// Response channel (rsp_): exactly one response per request, reporting the
// period, duty compare value, output enable and the zero-frequency error flag.
// A centisecond tick, an unused kind or a note whose integer frequency is
// zero answers in the cycle after acceptance. A note with a valid frequency
// and a PWM tick go through the shared restoring divider, one quotient bit
// per cycle, and answer once the divide state has produced all DIV_W bits
// and the done state has loaded the response register; DIV_W follows from
// the wider of the clock-rate numerator and the sine-times-period product.
// Only one request is handled at a time; req_tready is high only while the
// sequencer is idle and the response register is free or being emptied.
// Kinds that skip the divider can follow every cycle while rsp_tready stays
// high; a divider request holds off the next one until the sequencer idles.
// Reset: period and duty clear, the wave index and elapsed time clear, the
// output is enabled; no response is pending.
// A stalled receiver holds the response in its register and stops intake.
module sine_pwm_tone_generator #(
   parameter int TABLE_POINTS    = stg_pkg::DEF_TABLE_POINTS,
   parameter int AMPLITUDE_RANGE = stg_pkg::DEF_AMPLITUDE_RANGE,
   parameter int CLOCK_HZ        = stg_pkg::DEF_CLOCK_HZ
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [14:0] freq_decihz, [22:15] duration_cs, [23] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [15:0] period, [31:16] duty_compare,
                                    // [32] output_on, [33] freq_error, [39:34] zero
);
   import stg_pkg::*;

   localparam int WI_W   = $clog2(TABLE_POINTS);
   localparam int NUMER  = CLOCK_HZ / TABLE_POINTS;
   localparam int NUM_W  = $clog2(NUMER + 1);
   localparam int PROD_W = ROM_W + VAL_W;
   localparam int DIV_W  = (NUM_W > PROD_W) ? NUM_W : PROD_W;
   localparam int CNT_W  = $clog2(DIV_W + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Request fields
   logic [FREQ_W-1:0] req_freq;
   logic [DUR_W-1:0]  req_dur;
   assign req_freq = req_tdata[FREQ_W-1:0];
   assign req_dur  = req_tdata[FREQ_W +: DUR_W];

   // Architectural state
   logic [WI_W-1:0]     wave_index_ff, wave_index_in;
   logic [VAL_W-1:0]    period_ff, period_in;
   logic [VAL_W-1:0]    duty_ff, duty_in;
   logic [ELAPSE_W-1:0] elapsed_ff, elapsed_in;
   logic [DUR_W-1:0]    note_len_ff, note_len_in;
   logic                enable_ff, enable_in;

   // Sequencer and shared divider
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;     // dividend shifts out, quotient shifts in
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             op_note_ff, op_note_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 rsp_free;
   logic                 load_rsp;
   logic                 rsp_err;
   logic [DIV10_PROD_W-1:0] hz_prod;
   logic [HZ_W-1:0]      hz;
   logic [ROM_AW-1:0]    pos_tab [TABLE_POINTS];
   logic [ROM_W-1:0]     sine;
   logic [PROD_W-1:0]    product;
   logic [DEN_W:0]       rem_shift;
   logic                 qbit;
   logic [VAL_W-1:0]     quo_sat;

   // Wave index to ROM address, resampled when the table size is not 32
   for (genvar gi = 0; gi < TABLE_POINTS; gi++) begin : g_pos
      assign pos_tab[gi] = ROM_AW'((gi * ROM_SIZE) / TABLE_POINTS);
   end

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;

   assign hz_prod = DIV10_PROD_W'(req_freq) * DIV10_PROD_W'(DIV10_MUL);
   assign hz      = hz_prod[DIV10_SHIFT +: HZ_W];
   assign sine    = sine_value(pos_tab[wave_index_ff]);
   assign product = PROD_W'(sine) * PROD_W'(period_ff);

   // One restoring step: bring down the next dividend bit, trial subtract
   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign qbit      = rem_shift >= {1'b0, den_ff};
   assign quo_sat   = (|quo_ff[DIV_W-1:VAL_W]) ? MAX16 : quo_ff[VAL_W-1:0];

   always_comb begin
      wave_index_in = wave_index_ff;
      period_in     = period_ff;
      duty_in       = duty_ff;
      elapsed_in    = elapsed_ff;
      note_len_in   = note_len_ff;
      enable_in     = enable_ff;
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      op_note_in    = op_note_ff;
      load_rsp      = 1'b0;
      rsp_err       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  KIND_NOTE: begin
                     note_len_in = req_dur;
                     elapsed_in  = '0;
                     enable_in   = 1'b1;
                     if (hz == '0) begin
                        // keep the old period, flag the error
                        rsp_err  = 1'b1;
                        load_rsp = 1'b1;
                     end else begin
                        quo_in     = DIV_W'(NUMER);
                        rem_in     = '0;
                        den_in     = DEN_W'(hz);
                        cnt_in     = CNT_W'(DIV_W);
                        op_note_in = 1'b1;
                        state_in   = ST_DIV;
                     end
                  end
                  KIND_PWM: begin
                     quo_in     = DIV_W'(product);
                     rem_in     = '0;
                     den_in     = DEN_W'(AMPLITUDE_RANGE);
                     cnt_in     = CNT_W'(DIV_W);
                     op_note_in = 1'b0;
                     state_in   = ST_DIV;
                     wave_index_in = (wave_index_ff == WI_W'(TABLE_POINTS - 1)) ?
                                     '0 : wave_index_ff + 1'b1;
                  end
                  KIND_CSTICK: begin
                     if (elapsed_ff > ELAPSE_W'(note_len_ff)) begin
                        enable_in = 1'b0;
                     end else if (elapsed_ff < MAX_ELAPSED) begin
                        elapsed_in = elapsed_ff + 1'b1;
                     end
                     load_rsp = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[DIV_W-2:0], qbit};
            rem_in = qbit ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the quotient until the response register can take it
            if (rsp_free) begin
               if (op_note_ff) begin
                  period_in = quo_sat;
               end else begin
                  duty_in = quo_sat;
               end
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, rsp_err, enable_in, duty_in, period_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         wave_index_ff <= '0;
         period_ff     <= '0;
         duty_ff       <= '0;
         elapsed_ff    <= '0;
         note_len_ff   <= '0;
         enable_ff     <= 1'b1;
         cnt_ff        <= '0;
         op_note_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         wave_index_ff <= wave_index_in;
         period_ff     <= period_in;
         duty_ff       <= duty_in;
         elapsed_ff    <= elapsed_in;
         note_len_ff   <= note_len_in;
         enable_ff     <= enable_in;
         cnt_ff        <= cnt_in;
         op_note_ff    <= op_note_in;
      end
   end

   // Datapath registers, no reset needed
   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
